// ===== design/limit_order_matcher_macros.svh =====
// Assertion macros for the order matcher
`ifndef LIMIT_ORDER_MATCHER_MACROS_SVH
`define LIMIT_ORDER_MATCHER_MACROS_SVH

`ifndef SYNTHESIS
`define LOM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LOM_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> prop) else $error(msg);
`else
`define LOM_ASSERT(label, clk, rst_n, prop, msg)
`define LOM_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif

`endif

// ===== design/lom_pkg.sv =====
package lom_pkg;

    localparam int SYMBOL_COUNT = 8;
    localparam int ORDER_SLOTS  = 32;
    localparam int SLOT_W       = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
    localparam int CNT_W        = $clog2(ORDER_SLOTS + 1);

    localparam logic [1:0] KIND_NEW    = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_FLUSH  = 2'd2;

    localparam logic [2:0] EV_ACK        = 3'd0;
    localparam logic [2:0] EV_CANCEL_ACK = 3'd1;
    localparam logic [2:0] EV_TRADE      = 3'd2;
    localparam logic [2:0] EV_TOP        = 3'd3;
    localparam logic [2:0] EV_FULL       = 3'd4;

    typedef struct packed {
        logic [3:0]  symside;
        logic [47:0] key;
        logic [23:0] price;
        logic [23:0] remaining;
        logic [31:0] arrival;
    } slot_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic              valid;
        slot_t             data;
    } slot_wr_t;

    typedef struct packed {
        logic        top_present;
        logic        top_side;
        logic [28:0] qty;
        logic [23:0] price;
        logic [31:0] seller_order;
        logic [15:0] seller_client;
        logic [31:0] buyer_order;
        logic [15:0] buyer_client;
    } payload_t;

    typedef struct packed {
        logic [2:0] ev;
        payload_t   payload;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_PLACE,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        PH_LOOKUP,
        PH_MATCH,
        PH_TOP_OPP,
        PH_TOP_OWN,
        PH_CXL_BEST,
        PH_CXL_TOP
    } phase_t;

endpackage

// ===== design/limit_order_matcher.sv =====
// Each slot scan reads every slot once through the slot memory read port.
// A new order takes one lookup scan plus one scan per trade and per top-of-book update.
// Cancel takes 1 to 3 scans, flush needs no scan; one item at a time, results via a hold register.
// Reset (rst_n, async, active low) clears slot valid bits, the arrival counter,
// symbol_enable and all control state; slot contents stay undefined until written.
`include "limit_order_matcher_macros.svh"

module limit_order_matcher
    import lom_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // symbol, side, limit_price, quantity, client, order_id, zero pad
    input  logic [103:0] s_axis_tdata,
    // kind
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // buyer_client, buyer_order, seller_client, seller_order, price_out, qty_out,
    // top_side, top_present, zero pad
    output logic [151:0] m_axis_tdata,
    // event_res
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_data
);

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic [7:0]  enable_reg;
    logic [31:0] arrival_reg, arrival_next;

    logic [1:0]  kind_reg;
    logic [2:0]  sym_reg;
    logic        side_reg;
    logic [23:0] price_reg;
    logic [47:0] key_reg;
    logic [23:0] left_reg, left_next;
    logic        traded_reg, traded_next;
    logic        placed_reg, placed_next;
    logic [3:0]  target_reg, target_next;

    logic [CNT_W-1:0]  cnt_reg;
    logic              stage_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic              start_scan;

    logic              best_found_reg, match_found_reg, free_found_reg;
    slot_t             best_reg, match_reg;
    logic [SLOT_W-1:0] best_idx_reg, match_idx_reg, free_idx_reg;
    logic [28:0]       total_reg;

    slot_t    rd_data;
    logic     rd_valid;
    slot_wr_t wr;
    logic     flush;

    result_t out_reg, pend_reg, push_item;
    logic    out_valid_reg, out_last_reg, pend_valid_reg;
    logic    push_en, finish, can_push, out_free, accept;

    logic [3:0]  own_ss, opp_ss;
    logic [23:0] fill;
    logic        crosses;
    logic [23:0] rem_left;

    assign own_ss = {sym_reg, side_reg};
    assign opp_ss = {sym_reg, ~side_reg};

    lom_slot_mem u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .flush    (flush),
        .rd_addr  (cnt_reg[SLOT_W-1:0]),
        .rd_data  (rd_data),
        .rd_valid (rd_valid)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign can_push      = !pend_valid_reg || out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_reg.payload};
    assign m_axis_tuser  = out_reg.ev;
    assign m_axis_tlast  = out_last_reg;

    assign fill     = (left_reg < best_reg.remaining) ? left_reg : best_reg.remaining;
    assign rem_left = best_reg.remaining - fill;
    assign crosses  = best_found_reg &&
                      ((price_reg == 24'd0) ||
                       (side_reg ? (price_reg <= best_reg.price) : (price_reg >= best_reg.price)));

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        target_next  = target_reg;
        left_next    = left_reg;
        traded_next  = traded_reg;
        placed_next  = placed_reg;
        arrival_next = arrival_reg;
        start_scan   = 1'b0;
        push_en      = 1'b0;
        push_item    = '0;
        finish       = 1'b0;
        flush        = 1'b0;
        wr           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (s_axis_tuser == KIND_NEW || s_axis_tuser == KIND_CANCEL)
                    begin
                        start_scan  = 1'b1;
                        phase_next  = PH_LOOKUP;
                        target_next = {s_axis_tdata[2:0], ~s_axis_tdata[3]};
                        left_next   = s_axis_tdata[51:28];
                        traded_next = 1'b0;
                        placed_next = 1'b0;
                        state_next  = S_SCAN;
                    end
                    else if (s_axis_tuser == KIND_FLUSH)
                    begin
                        flush = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                if (cnt_reg == CNT_W'(ORDER_SLOTS) && !stage_reg)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                unique case (phase_reg)
                    PH_LOOKUP:
                    begin
                        if (kind_reg == KIND_NEW)
                        begin
                            if (match_found_reg || !enable_reg[sym_reg])
                            begin
                                state_next = S_DONE;
                            end
                            else if (can_push)
                            begin
                                push_en                        = 1'b1;
                                push_item.ev                   = EV_ACK;
                                push_item.payload.buyer_client = key_reg[47:32];
                                push_item.payload.buyer_order  = key_reg[31:0];
                                phase_next                     = PH_MATCH;
                            end
                        end
                        else if (!match_found_reg)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            target_next = match_reg.symside;
                            phase_next  = PH_CXL_BEST;
                            start_scan  = 1'b1;
                            state_next  = S_SCAN;
                        end
                    end
                    PH_MATCH:
                    begin
                        if (left_reg != 24'd0 && crosses)
                        begin
                            if (can_push)
                            begin
                                push_en                 = 1'b1;
                                push_item.ev            = EV_TRADE;
                                push_item.payload.price = best_reg.price;
                                push_item.payload.qty   = 29'(fill);
                                if (side_reg)
                                begin
                                    push_item.payload.buyer_client  = best_reg.key[47:32];
                                    push_item.payload.buyer_order   = best_reg.key[31:0];
                                    push_item.payload.seller_client = key_reg[47:32];
                                    push_item.payload.seller_order  = key_reg[31:0];
                                end
                                else
                                begin
                                    push_item.payload.buyer_client  = key_reg[47:32];
                                    push_item.payload.buyer_order   = key_reg[31:0];
                                    push_item.payload.seller_client = best_reg.key[47:32];
                                    push_item.payload.seller_order  = best_reg.key[31:0];
                                end
                                wr.en                = 1'b1;
                                wr.addr              = best_idx_reg;
                                wr.valid             = (rem_left != 24'd0);
                                wr.data              = best_reg;
                                wr.data.remaining    = rem_left;
                                left_next            = left_reg - fill;
                                traded_next          = 1'b1;
                                start_scan           = 1'b1;
                                state_next           = S_SCAN;
                            end
                        end
                        else
                        begin
                            state_next = S_PLACE;
                        end
                    end
                    PH_TOP_OPP, PH_TOP_OWN, PH_CXL_TOP:
                    begin
                        if (phase_reg == PH_TOP_OWN &&
                            !(best_found_reg && best_reg.price == price_reg))
                        begin
                            state_next = S_DONE;
                        end
                        else if (can_push)
                        begin
                            push_en                       = 1'b1;
                            push_item.ev                  = EV_TOP;
                            push_item.payload.top_side    = target_reg[0];
                            push_item.payload.top_present = best_found_reg;
                            if (best_found_reg)
                            begin
                                push_item.payload.price = best_reg.price;
                                push_item.payload.qty   = total_reg;
                            end
                            if (phase_reg == PH_TOP_OPP && placed_reg)
                            begin
                                target_next = own_ss;
                                phase_next  = PH_TOP_OWN;
                                start_scan  = 1'b1;
                                state_next  = S_SCAN;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                    end
                    PH_CXL_BEST:
                    begin
                        if (can_push)
                        begin
                            push_en                        = 1'b1;
                            push_item.ev                   = EV_CANCEL_ACK;
                            push_item.payload.buyer_client = key_reg[47:32];
                            push_item.payload.buyer_order  = key_reg[31:0];
                            wr.en                          = 1'b1;
                            wr.addr                        = match_idx_reg;
                            wr.valid                       = 1'b0;
                            wr.data                        = match_reg;
                            if (best_found_reg && best_reg.price == match_reg.price)
                            begin
                                phase_next = PH_CXL_TOP;
                                start_scan = 1'b1;
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_PLACE:
            begin
                if (!(left_reg != 24'd0 && price_reg != 24'd0 && !free_found_reg) || can_push)
                begin
                    if (left_reg != 24'd0 && price_reg != 24'd0)
                    begin
                        if (!free_found_reg)
                        begin
                            push_en                        = 1'b1;
                            push_item.ev                   = EV_FULL;
                            push_item.payload.buyer_client = key_reg[47:32];
                            push_item.payload.buyer_order  = key_reg[31:0];
                        end
                        else
                        begin
                            wr.en                = 1'b1;
                            wr.addr              = free_idx_reg;
                            wr.valid             = 1'b1;
                            wr.data.symside      = own_ss;
                            wr.data.key          = key_reg;
                            wr.data.price        = price_reg;
                            wr.data.remaining    = left_reg;
                            wr.data.arrival      = arrival_reg;
                            arrival_next         = arrival_reg + 32'd1;
                            placed_next          = 1'b1;
                        end
                    end
                    priority if (traded_reg)
                    begin
                        target_next = opp_ss;
                        phase_next  = PH_TOP_OPP;
                        start_scan  = 1'b1;
                        state_next  = S_SCAN;
                    end
                    else if (placed_next)
                    begin
                        target_next = own_ss;
                        phase_next  = PH_TOP_OWN;
                        start_scan  = 1'b1;
                        state_next  = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            phase_reg   <= PH_LOOKUP;
            enable_reg  <= '0;
            arrival_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            arrival_reg <= arrival_next;
            if (cfg_valid && cfg_ready)
            begin
                enable_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= s_axis_tuser;
            sym_reg   <= s_axis_tdata[2:0];
            side_reg  <= s_axis_tdata[3];
            price_reg <= s_axis_tdata[27:4];
            key_reg   <= {s_axis_tdata[67:52], s_axis_tdata[99:68]};
        end
        left_reg   <= left_next;
        traded_reg <= traded_next;
        placed_reg <= placed_next;
        target_reg <= target_next;
    end

    // slot scan: issue one read a cycle, fold the returned entry in the cycle after
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg         <= CNT_W'(ORDER_SLOTS);
            stage_reg       <= 1'b0;
            best_found_reg  <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else if (start_scan)
        begin
            cnt_reg        <= '0;
            stage_reg      <= 1'b0;
            best_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            if (phase_next == PH_LOOKUP)
            begin
                match_found_reg <= 1'b0;
            end
        end
        else
        begin
            stage_reg <= (state_reg == S_SCAN) && (cnt_reg != CNT_W'(ORDER_SLOTS));
            if (state_reg == S_SCAN && cnt_reg != CNT_W'(ORDER_SLOTS))
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (stage_reg)
            begin
                if (!rd_valid)
                begin
                    free_found_reg <= 1'b1;
                end
                if (rd_valid && phase_reg == PH_LOOKUP && rd_data.key == key_reg)
                begin
                    match_found_reg <= 1'b1;
                end
                if (rd_valid && rd_data.symside == target_reg)
                begin
                    best_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_scan)
        begin
            total_reg <= '0;
        end
        else if (stage_reg)
        begin
            if (!rd_valid && !free_found_reg)
            begin
                free_idx_reg <= idx_reg;
            end
            if (rd_valid && phase_reg == PH_LOOKUP && rd_data.key == key_reg && !match_found_reg)
            begin
                match_idx_reg <= idx_reg;
                match_reg     <= rd_data;
            end
            if (rd_valid && rd_data.symside == target_reg)
            begin
                if (!best_found_reg ||
                    (rd_data.price != best_reg.price &&
                     (target_reg[0] ? (rd_data.price < best_reg.price)
                                    : (rd_data.price > best_reg.price))))
                begin
                    best_reg     <= rd_data;
                    best_idx_reg <= idx_reg;
                    total_reg    <= 29'(rd_data.remaining);
                end
                else if (rd_data.price == best_reg.price)
                begin
                    total_reg <= total_reg + 29'(rd_data.remaining);
                    if ((arrival_reg - rd_data.arrival) > (arrival_reg - best_reg.arrival))
                    begin
                        best_reg     <= rd_data;
                        best_idx_reg <= idx_reg;
                    end
                end
            end
        end
        idx_reg <= cnt_reg[SLOT_W-1:0];
    end

    // result path: hold one result back so the final one can carry last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (finish || (push_en && pend_valid_reg))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (finish)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (push_en)
            begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish || (push_en && pend_valid_reg))
        begin
            out_reg      <= pend_reg;
            out_last_reg <= finish;
        end
        if (push_en)
        begin
            pend_reg <= push_item;
        end
    end

    `LOM_ASSERT(a_ready_idle, clk, rst_n, s_axis_tready |-> !pend_valid_reg,
                "input taken while a result is still held")
    `LOM_ASSERT(a_push_room, clk, rst_n, (push_en && pend_valid_reg) |-> out_free,
                "result pushed with no room in the output register")
    `LOM_ASSERT(a_no_write_in_scan, clk, rst_n, wr.en |-> (state_reg != S_SCAN),
                "slot write during a scan")
    `LOM_ASSERT(a_cnt_range, clk, rst_n, cnt_reg <= CNT_W'(ORDER_SLOTS),
                "scan counter beyond slot count")
    `LOM_ASSERT_NEXT(a_finish_last, clk, rst_n, finish, m_axis_tvalid && m_axis_tlast,
                     "final result not presented with last")

endmodule

// ===== design/lom_slot_mem.sv =====
module lom_slot_mem
    import lom_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  slot_wr_t          wr,
    input  logic              flush,
    input  logic [SLOT_W-1:0] rd_addr,
    output slot_t             rd_data,
    output logic              rd_valid
);

    slot_t                  mem [ORDER_SLOTS];
    logic [ORDER_SLOTS-1:0] valid_reg;
    slot_t                  rd_data_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (flush)
            begin
                valid_reg <= '0;
            end
            else if (wr.en)
            begin
                valid_reg[wr.addr] <= wr.valid;
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule
